>>> sv/mmfn_pkg.sv
// Package for the min-max feature normaliser: opcodes, widths, the state type
// and the command and status structs between the controller and the datapath.
// No dependencies.
package mmfn_pkg;

    localparam int FEATURES  = 16;
    localparam int IDX_W     = $clog2(FEATURES);
    localparam int DATA_W    = 16;
    localparam int RES_W     = 18;
    localparam int DIV_STEPS = 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_CLEAR     = 2'd0;
    localparam opcode_t OP_SCAN      = 2'd1;
    localparam opcode_t OP_NORMALIZE = 2'd2;

    // Full scale of an unsigned Q0.16 value.
    localparam logic [RES_W-1:0] Q16_ONE = 18'h10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CLASSIFY,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic classify;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_normalize;
        logic needs_divide;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

>>> sv/mmfn_ctrl.sv
// Controller state machine of the min-max feature normaliser.
// Depends on mmfn_pkg for the state type and the command and status structs.
module mmfn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mmfn_pkg::status_t status,
    output mmfn_pkg::cmd_t    cmd
);

    mmfn_pkg::state_t state_reg;
    mmfn_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mmfn_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mmfn_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = mmfn_pkg::ST_LOOKUP;
                end
            end
            mmfn_pkg::ST_LOOKUP: begin
                state_next = status.is_normalize ? mmfn_pkg::ST_CLASSIFY : mmfn_pkg::ST_IDLE;
            end
            mmfn_pkg::ST_CLASSIFY: begin
                state_next = status.needs_divide ? mmfn_pkg::ST_DIVIDE : mmfn_pkg::ST_EMIT;
            end
            mmfn_pkg::ST_DIVIDE: begin
                if (status.div_last) begin
                    state_next = mmfn_pkg::ST_EMIT;
                end
            end
            mmfn_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = mmfn_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mmfn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            mmfn_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            mmfn_pkg::ST_LOOKUP: begin
                cmd.lookup = 1'b1;
            end
            mmfn_pkg::ST_CLASSIFY: begin
                cmd.classify = 1'b1;
            end
            mmfn_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            mmfn_pkg::ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/mmfn_datapath.sv
// Datapath of the min-max feature normaliser: per-feature statistics, the
// restoring divider and the output register. Depends on mmfn_pkg.
module mmfn_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mmfn_pkg::cmd_t                      cmd,
    output mmfn_pkg::status_t                   status,
    input  logic [1:0]                          s_opcode,
    input  logic [3:0]                          s_feature_index,
    input  logic signed [mmfn_pkg::DATA_W-1:0]  s_sample_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mmfn_pkg::RES_W-1:0]   m_normalized_value,
    output logic                                m_unchanged
);

    // Statistics stores; an entry is only meaningful while its seen bit is set.
    logic signed [mmfn_pkg::DATA_W-1:0] min_mem [mmfn_pkg::FEATURES];
    logic signed [mmfn_pkg::DATA_W-1:0] max_mem [mmfn_pkg::FEATURES];

    logic [mmfn_pkg::FEATURES-1:0]      seen_reg;
    logic [mmfn_pkg::FEATURES-1:0]      seen_next;

    mmfn_pkg::opcode_t                  op_reg;
    logic [mmfn_pkg::IDX_W-1:0]         idx_reg;
    logic signed [mmfn_pkg::DATA_W-1:0] value_reg;

    logic                               hit_reg;
    logic [mmfn_pkg::DATA_W:0]          diff_reg;
    logic [mmfn_pkg::DATA_W-1:0]        range_reg;

    logic [mmfn_pkg::DATA_W-1:0]        rem_reg;
    logic [mmfn_pkg::DATA_W-1:0]        rem_next;
    logic [mmfn_pkg::DATA_W-1:0]        quo_reg;
    logic [mmfn_pkg::DATA_W-1:0]        quo_next;
    logic [mmfn_pkg::CNT_W-1:0]         cnt_reg;

    logic [mmfn_pkg::RES_W-1:0]         res_value_reg;
    logic                               res_unch_reg;

    logic                               m_valid_reg;
    logic                               m_valid_next;
    logic [mmfn_pkg::RES_W-1:0]         m_value_reg;
    logic                               m_unch_reg;

    logic                               pass_through;
    logic                               non_positive;
    logic                               saturate;
    logic [mmfn_pkg::DATA_W:0]          shifted;
    logic                               step_ge;
    logic [mmfn_pkg::DATA_W:0]          step_sub;

    // Input capture.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_opcode;
            idx_reg   <= s_feature_index[mmfn_pkg::IDX_W-1:0];
            value_reg <= s_sample_value;
        end
    end

    // Seen bits.
    always_comb begin
        seen_next = seen_reg;
        if (cmd.lookup) begin
            case (op_reg)
                mmfn_pkg::OP_CLEAR: seen_next = '0;
                mmfn_pkg::OP_SCAN:  seen_next[idx_reg] = 1'b1;
                default:            seen_next = seen_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else begin
            seen_reg <= seen_next;
        end
    end

    // Statistics update on a scan, and operand preparation for a normalise.
    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            hit_reg   <= seen_reg[idx_reg];
            diff_reg  <= {value_reg[mmfn_pkg::DATA_W-1], value_reg}
                       - {min_mem[idx_reg][mmfn_pkg::DATA_W-1], min_mem[idx_reg]};
            range_reg <= max_mem[idx_reg] - min_mem[idx_reg];
            if (op_reg == mmfn_pkg::OP_SCAN) begin
                if (!seen_reg[idx_reg]) begin
                    min_mem[idx_reg] <= value_reg;
                    max_mem[idx_reg] <= value_reg;
                end else begin
                    if (value_reg < min_mem[idx_reg]) begin
                        min_mem[idx_reg] <= value_reg;
                    end
                    if (value_reg > max_mem[idx_reg]) begin
                        max_mem[idx_reg] <= value_reg;
                    end
                end
            end
        end
    end

    // Classification of a normalise item.
    assign pass_through = !hit_reg || (range_reg == '0);
    assign non_positive = diff_reg[mmfn_pkg::DATA_W] || (diff_reg == '0);
    assign saturate     = diff_reg >= {1'b0, range_reg};

    // One restoring division step: the remainder stays below the range.
    assign shifted  = {rem_reg, 1'b0};
    assign step_ge  = shifted >= {1'b0, range_reg};
    assign step_sub = shifted - {1'b0, range_reg};
    assign rem_next = step_ge ? step_sub[mmfn_pkg::DATA_W-1:0]
                              : shifted[mmfn_pkg::DATA_W-1:0];
    assign quo_next = {quo_reg[mmfn_pkg::DATA_W-2:0], step_ge};

    always_ff @(posedge aclk) begin
        if (cmd.classify) begin
            rem_reg <= diff_reg[mmfn_pkg::DATA_W-1:0];
            quo_reg <= '0;
            cnt_reg <= '0;
            if (pass_through) begin
                res_value_reg <= {{(mmfn_pkg::RES_W - mmfn_pkg::DATA_W)
                                   {value_reg[mmfn_pkg::DATA_W-1]}}, value_reg};
                res_unch_reg  <= 1'b1;
            end else if (non_positive) begin
                res_value_reg <= '0;
                res_unch_reg  <= 1'b0;
            end else begin
                res_value_reg <= mmfn_pkg::Q16_ONE;
                res_unch_reg  <= 1'b0;
            end
        end else if (cmd.div_step) begin
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            cnt_reg       <= cnt_reg + 1'b1;
            res_value_reg <= {{(mmfn_pkg::RES_W - mmfn_pkg::DATA_W){1'b0}}, quo_next};
            res_unch_reg  <= 1'b0;
        end
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_value_reg <= res_value_reg;
            m_unch_reg  <= res_unch_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_normalized_value = m_value_reg;
    assign m_unchanged        = m_unch_reg;

    assign status.is_normalize = (op_reg == mmfn_pkg::OP_NORMALIZE);
    assign status.needs_divide = !pass_through && !non_positive && !saturate;
    assign status.div_last     = (cnt_reg == mmfn_pkg::CNT_W'(mmfn_pkg::DIV_STEPS - 1));
    assign status.out_free     = !m_valid_reg || m_ready;

endmodule

>>> sv/min_max_feature_normalizer.sv
// Top level of the per-feature min-max normaliser.
// Depends on mmfn_pkg, mmfn_ctrl and mmfn_datapath.
//
// Usage: the input channel (s_valid, s_ready) carries one item made of an
// opcode, a feature index and a signed Q8.8 sample. A clear item forgets the
// statistics of every feature, a scan item widens the stored minimum and
// maximum of its feature, and a normalise item returns one result on the
// output channel (m_valid, m_ready): (value - min) / (max - min) as unsigned
// Q0.16, saturated to 0..65536, or the raw value sign-extended with the
// unchanged flag set when the feature was never scanned or its range is zero.
// Other items produce no result.
// The block works on one item at a time. A clear or scan item passes through
// its lookup step and returns to idle. A normalise item goes on through the
// classify step, the divide step only when it needs division, and the emit
// step, which writes the output register; the next item can be taken in the
// cycle after that. The divide step runs the restoring divider, which
// produces one quotient bit per cycle.
// The output register holds a finished result while the receiver stalls; the
// block keeps working on a following clear or scan item meanwhile, and only
// waits in its emit step when a second result is ready before the first has
// been taken. Reset (aresetn low at a clock edge) empties the output register
// and marks every feature as unseen; the stored extremes need no clearing.
module min_max_feature_normalizer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_opcode,
    input  logic [3:0]                          s_feature_index,
    input  logic signed [mmfn_pkg::DATA_W-1:0]  s_sample_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mmfn_pkg::RES_W-1:0]   m_normalized_value,
    output logic                                m_unchanged
);

    // Commands flow from the controller to the datapath, status flows back.
    mmfn_pkg::cmd_t    cmd;
    mmfn_pkg::status_t status;

    mmfn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mmfn_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_opcode           (s_opcode),
        .s_feature_index    (s_feature_index),
        .s_sample_value     (s_sample_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_normalized_value (m_normalized_value),
        .m_unchanged        (m_unchanged)
    );

endmodule
